// ===== rtl/pnmsd_pkg.sv =====
package pnmsd_pkg;

    // Largest accepted width or height, and the width needed to hold it.
    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);

    // Number accumulator and the width of its multiply-add result.
    localparam int ACC_W     = 16;
    localparam int ACC_EXT_W = ACC_W + 4;

    // Output field widths.
    localparam int COORD_W   = 12;
    localparam int SIZE_W    = 13;

    // Command queue between the parser and the pixel expander.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Characters and values that the header parser looks for.
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [ACC_W-1:0] MAXVAL_OK = 16'd255;
    localparam logic [7:0] LEVEL_WHITE = 8'hFF;
    localparam logic [7:0] LEVEL_BLACK = 8'h00;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [3:0] {
        PH_MAGIC_P = 4'd0,
        PH_MAGIC_D = 4'd1,
        PH_W_SKIP  = 4'd2,
        PH_W_DIG   = 4'd3,
        PH_H_SKIP  = 4'd4,
        PH_H_DIG   = 4'd5,
        PH_M_SKIP  = 4'd6,
        PH_M_DIG   = 4'd7,
        PH_RASTER  = 4'd8,
        PH_DONE    = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        FMT_NONE = 2'd0,
        FMT_P4   = 2'd1,
        FMT_P5   = 2'd2,
        FMT_P6   = 2'd3
    } t_fmt;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_MAGIC     = 3'd1,
        ERR_NUMBER    = 3'd2,
        ERR_MAXVAL    = 3'd3,
        ERR_TOO_LARGE = 3'd4
    } t_err;

    // One queued command: a header, an error, or a run of one to eight pixels.
    typedef struct packed {
        t_kind            kind;
        t_err             err;
        logic             p4;
        logic [3:0]       count;
        logic             done;
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [7:0]       bits;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_cmd;

endpackage

// ===== rtl/pnm_stream_decoder.sv =====
// A byte's results pass through the command queue and then the output register.
// Results go out at one per cycle while the output is not stalled; a P4 byte
// yields up to eight pixels, one after another from the pixel expander, and
// other bytes at most one result. A four-entry command queue lets the parser keep taking
// bytes meanwhile. Reset is synchronous and active low; it empties the queue and output stage.
module pnm_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_file,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic [11:0] o_pixel_x,
    output logic [11:0] o_pixel_y,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [12:0] o_image_width,
    output logic [12:0] o_image_height,
    output logic [2:0]  o_error_code,
    output logic        o_image_done,
    output logic        o_run_last
);
    import pnmsd_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;

    assign o_stall = q_full;

    // Header parser and raster position tracking.
    pnmsd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_cmd           (push_cmd)
    );

    // Command queue.
    pnmsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // Pixel expander and output register.
    pnmsd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_cmd        (head_cmd),
        .o_q_pop        (q_pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_result_kind  (o_result_kind),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_error_code   (o_error_code),
        .o_image_done   (o_image_done),
        .o_run_last     (o_run_last)
    );

endmodule

// ===== rtl/pnmsd_front.sv =====
module pnmsd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_data_byte,
    input  logic          i_start_of_file,
    input  logic          i_q_full,
    output logic          o_push,
    output pnmsd_pkg::t_cmd o_cmd
);
    import pnmsd_pkg::*;

    t_phase r_phase, n_phase;
    t_fmt   r_fmt, n_fmt;
    logic   r_comment, n_comment;
    logic   r_halted, n_halted;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [DIM_W-1:0] r_width, n_width;
    logic [DIM_W-1:0] r_height, n_height;
    logic [DIM_W-1:0] r_col, n_col;
    logic [DIM_W-1:0] r_row, n_row;
    logic [1:0] r_chan, n_chan;
    logic [7:0] r_red, n_red;
    logic [7:0] r_green, n_green;

    logic       accept;
    t_phase     cur_phase;
    logic       cur_comment;
    logic       cur_halted;
    logic       live;
    logic       in_header;
    logic       is_digit;
    logic       is_space;
    logic [ACC_EXT_W-1:0] acc_next;
    logic       acc_ovf;
    logic       acc_big;
    logic [DIM_W-1:0] rem;
    logic [3:0] cnt;
    logic [DIM_W-1:0] col_sum;
    logic [DIM_W-1:0] row_inc;
    logic       row_end;
    logic       img_end;
    logic       ev_hdr;
    logic       ev_pix;
    t_err       ev_err;

    // A start-of-file byte sees the parser in its reset state.
    assign accept      = i_valid && !i_q_full;
    assign cur_phase   = i_start_of_file ? PH_MAGIC_P : r_phase;
    assign cur_comment = i_start_of_file ? 1'b0 : r_comment;
    assign cur_halted  = i_start_of_file ? 1'b0 : r_halted;
    assign live        = !cur_halted && (cur_phase != PH_DONE);
    assign in_header   = (cur_phase != PH_RASTER) && (cur_phase != PH_DONE);

    // Character classes and the decimal accumulator step.
    assign is_digit = (i_data_byte >= CH_0) && (i_data_byte <= CH_9);
    assign is_space = (i_data_byte == CH_SPACE) || (i_data_byte == CH_LF)
                   || (i_data_byte == CH_TAB);
    assign acc_next = ACC_EXT_W'(r_acc) * ACC_EXT_W'(10)
                    + ACC_EXT_W'(i_data_byte[3:0]);
    assign acc_ovf  = (acc_next[ACC_EXT_W-1:ACC_W] != '0);
    assign acc_big  = (ACC_EXT_W'(r_acc) > ACC_EXT_W'(MAX_DIM));

    // Raster position step: a P4 byte covers up to eight pixels of one row.
    assign rem     = r_width - r_col;
    assign cnt     = (r_fmt != FMT_P4) ? 4'd1
                   : (rem > DIM_W'(BITS_PER_BYTE)) ? BITS_PER_BYTE : rem[3:0];
    assign col_sum = r_col + DIM_W'(cnt);
    assign row_inc = r_row + DIM_W'(1);
    assign row_end = (col_sum >= r_width);
    assign img_end = row_end && (row_inc >= r_height);

    // Next state and the events that the current byte raises.
    always_comb begin
        n_phase   = r_phase;
        n_fmt     = r_fmt;
        n_comment = r_comment;
        n_halted  = r_halted;
        n_acc     = r_acc;
        n_width   = r_width;
        n_height  = r_height;
        n_col     = r_col;
        n_row     = r_row;
        n_chan    = r_chan;
        n_red     = r_red;
        n_green   = r_green;
        ev_hdr    = 1'b0;
        ev_pix    = 1'b0;
        ev_err    = ERR_NONE;
        if (accept) begin
            if (i_start_of_file) begin
                n_phase   = PH_MAGIC_P;
                n_fmt     = FMT_NONE;
                n_comment = 1'b0;
                n_halted  = 1'b0;
                n_acc     = '0;
            end
            if (live && in_header) begin
                if (cur_comment) begin
                    if (i_data_byte == CH_LF) begin
                        n_comment = 1'b0;
                    end
                end else if (i_data_byte == CH_HASH) begin
                    n_comment = 1'b1;
                end
                if (!(cur_comment && i_data_byte != CH_LF)
                    && !(!cur_comment && i_data_byte == CH_HASH)) begin
                    case (cur_phase)
                        PH_MAGIC_P: begin
                            if (i_data_byte == CH_P) begin
                                n_phase = PH_MAGIC_D;
                            end else begin
                                ev_err = ERR_MAGIC;
                            end
                        end
                        PH_MAGIC_D: begin
                            if (i_data_byte == CH_4) begin
                                n_fmt   = FMT_P4;
                                n_phase = PH_W_SKIP;
                            end else if (i_data_byte == CH_5) begin
                                n_fmt   = FMT_P5;
                                n_phase = PH_W_SKIP;
                            end else if (i_data_byte == CH_6) begin
                                n_fmt   = FMT_P6;
                                n_phase = PH_W_SKIP;
                            end else begin
                                ev_err = ERR_MAGIC;
                            end
                        end
                        PH_W_SKIP, PH_H_SKIP, PH_M_SKIP: begin
                            if (!is_space) begin
                                if (!is_digit) begin
                                    ev_err = ERR_NUMBER;
                                end else begin
                                    n_acc = ACC_W'(i_data_byte[3:0]);
                                    case (cur_phase)
                                        PH_W_SKIP: n_phase = PH_W_DIG;
                                        PH_H_SKIP: n_phase = PH_H_DIG;
                                        default:   n_phase = PH_M_DIG;
                                    endcase
                                end
                            end
                        end
                        PH_W_DIG, PH_H_DIG, PH_M_DIG: begin
                            if (is_digit) begin
                                if (acc_ovf) begin
                                    ev_err = ERR_NUMBER;
                                end else begin
                                    n_acc = acc_next[ACC_W-1:0];
                                end
                            end else if (cur_phase == PH_W_DIG) begin
                                if (acc_big) begin
                                    ev_err = ERR_TOO_LARGE;
                                end else begin
                                    n_width = DIM_W'(r_acc);
                                    n_phase = PH_H_SKIP;
                                end
                            end else if (cur_phase == PH_H_DIG) begin
                                if (acc_big) begin
                                    ev_err = ERR_TOO_LARGE;
                                end else begin
                                    n_height = DIM_W'(r_acc);
                                    if (r_fmt == FMT_P4) begin
                                        ev_hdr = 1'b1;
                                    end else begin
                                        n_phase = PH_M_SKIP;
                                    end
                                end
                            end else if (r_acc != MAXVAL_OK) begin
                                ev_err = ERR_MAXVAL;
                            end else begin
                                ev_hdr = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end else if (live) begin
                // Raster bytes: P6 gathers red and green before a pixel goes out.
                if (r_fmt == FMT_P6 && r_chan == 2'd0) begin
                    n_red  = i_data_byte;
                    n_chan = 2'd1;
                end else if (r_fmt == FMT_P6 && r_chan == 2'd1) begin
                    n_green = i_data_byte;
                    n_chan  = 2'd2;
                end else begin
                    ev_pix = 1'b1;
                    n_chan = 2'd0;
                    if (row_end) begin
                        n_col = '0;
                        n_row = row_inc;
                        if (img_end) begin
                            n_phase = PH_DONE;
                        end
                    end else begin
                        n_col = col_sum;
                    end
                end
            end
            if (ev_hdr) begin
                n_col   = '0;
                n_row   = '0;
                n_chan  = 2'd0;
                n_phase = (n_width == '0 || n_height == '0) ? PH_DONE : PH_RASTER;
            end
            if (ev_err != ERR_NONE) begin
                n_halted = 1'b1;
            end
        end
    end

    // Command for the queue.
    always_comb begin
        o_push       = ev_hdr || ev_pix || (ev_err != ERR_NONE);
        o_cmd        = '0;
        o_cmd.count  = 4'd1;
        o_cmd.err    = ev_err;
        o_cmd.width  = n_width;
        o_cmd.height = n_height;
        if (ev_err != ERR_NONE) begin
            o_cmd.kind = KIND_ERROR;
        end else if (ev_hdr) begin
            o_cmd.kind = KIND_HEADER;
        end else begin
            o_cmd.kind  = KIND_PIXEL;
            o_cmd.p4    = (r_fmt == FMT_P4);
            o_cmd.count = cnt;
            o_cmd.done  = img_end;
            o_cmd.x     = r_col;
            o_cmd.y     = r_row;
            o_cmd.bits  = i_data_byte;
            o_cmd.red   = (r_fmt == FMT_P6) ? r_red : i_data_byte;
            o_cmd.green = (r_fmt == FMT_P6) ? r_green : i_data_byte;
            o_cmd.blue  = i_data_byte;
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MAGIC_P;
            r_fmt     <= FMT_NONE;
            r_comment <= 1'b0;
            r_halted  <= 1'b0;
            r_acc     <= '0;
            r_width   <= '0;
            r_height  <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_chan    <= 2'd0;
        end else begin
            r_phase   <= n_phase;
            r_fmt     <= n_fmt;
            r_comment <= n_comment;
            r_halted  <= n_halted;
            r_acc     <= n_acc;
            r_width   <= n_width;
            r_height  <= n_height;
            r_col     <= n_col;
            r_row     <= n_row;
            r_chan    <= n_chan;
        end
    end

    // Held color channels need no reset.
    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
    end

endmodule

// ===== rtl/pnmsd_queue.sv =====
module pnmsd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pnmsd_pkg::t_cmd i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output pnmsd_pkg::t_cmd o_cmd
);
    import pnmsd_pkg::*;

    t_cmd r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QPTR_W:0]   r_count, n_count;

    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    // Pointer and fill updates.
    always_comb begin
        n_wr    = i_push ? r_wr + QPTR_W'(1) : r_wr;
        n_rd    = i_pop ? r_rd + QPTR_W'(1) : r_rd;
        n_count = r_count + (QPTR_W + 1)'(i_push) - (QPTR_W + 1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("command popped from an empty queue");

endmodule

// ===== rtl/pnmsd_back.sv =====
module pnmsd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  pnmsd_pkg::t_cmd i_q_cmd,
    output logic            o_q_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [1:0]      o_result_kind,
    output logic [11:0]     o_pixel_x,
    output logic [11:0]     o_pixel_y,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue,
    output logic [12:0]     o_image_width,
    output logic [12:0]     o_image_height,
    output logic [2:0]      o_error_code,
    output logic            o_image_done,
    output logic            o_run_last
);
    import pnmsd_pkg::*;

    logic        r_ovalid;
    logic [2:0]  r_idx, n_idx;
    logic [1:0]  r_kind, n_kind;
    logic [COORD_W-1:0] r_x, n_x;
    logic [COORD_W-1:0] r_y, n_y;
    logic [7:0]  r_red, n_red;
    logic [7:0]  r_green, n_green;
    logic [7:0]  r_blue, n_blue;
    logic [SIZE_W-1:0] r_w, n_w;
    logic [SIZE_W-1:0] r_h, n_h;
    logic [2:0]  r_err, n_err;
    logic        r_done, n_done;
    logic        r_last, n_last;

    logic        load;
    logic        last;
    logic        bit_set;
    logic [7:0]  level;

    // The output register takes a new result when it is empty or being taken.
    assign load    = i_q_valid && (!r_ovalid || !i_stall);
    assign last    = ({1'b0, r_idx} == i_q_cmd.count - 4'd1);
    assign o_q_pop = load && last;
    assign bit_set = i_q_cmd.bits[3'd7 - r_idx];
    assign level   = bit_set ? LEVEL_BLACK : LEVEL_WHITE;

    // Result fields for the head command at the current pixel index.
    always_comb begin
        n_idx   = load ? (last ? 3'd0 : r_idx + 3'd1) : r_idx;
        n_kind  = i_q_cmd.kind;
        n_x     = '0;
        n_y     = '0;
        n_red   = '0;
        n_green = '0;
        n_blue  = '0;
        n_w     = '0;
        n_h     = '0;
        n_err   = '0;
        n_done  = 1'b0;
        n_last  = last;
        case (i_q_cmd.kind)
            KIND_PIXEL: begin
                n_x    = COORD_W'(i_q_cmd.x + DIM_W'(r_idx));
                n_y    = COORD_W'(i_q_cmd.y);
                n_done = i_q_cmd.done && last;
                if (i_q_cmd.p4) begin
                    n_red   = level;
                    n_green = level;
                    n_blue  = level;
                end else begin
                    n_red   = i_q_cmd.red;
                    n_green = i_q_cmd.green;
                    n_blue  = i_q_cmd.blue;
                end
            end
            KIND_HEADER: begin
                n_w = SIZE_W'(i_q_cmd.width);
                n_h = SIZE_W'(i_q_cmd.height);
            end
            KIND_ERROR: begin
                n_err = i_q_cmd.err;
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_idx    <= 3'd0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= n_kind;
            r_x     <= n_x;
            r_y     <= n_y;
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_w     <= n_w;
            r_h     <= n_h;
            r_err   <= n_err;
            r_done  <= n_done;
            r_last  <= n_last;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_result_kind  = r_kind;
    assign o_pixel_x      = r_x;
    assign o_pixel_y      = r_y;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_image_width  = r_w;
    assign o_image_height = r_h;
    assign o_error_code   = r_err;
    assign o_image_done   = r_done;
    assign o_run_last     = r_last;

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> ({1'b0, r_idx} < i_q_cmd.count))
        else $error("pixel index ran past the command's pixel count");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_done) |-> r_last)
        else $error("final image pixel not marked as last of its byte");

endmodule
